/* rtl/rth_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
package rth_pkg;

	localparam int CHANNEL_BITS_DEF = 8;
	localparam int HUE_BITS = 9;
	localparam int HUE_FRAC_BITS = 6;

	localparam logic [HUE_BITS-1:0] HUE_RED_BASE = 9'd360;
	localparam logic [HUE_BITS-1:0] HUE_GREEN_BASE = 9'd120;
	localparam logic [HUE_BITS-1:0] HUE_BLUE_BASE = 9'd240;

	typedef enum logic [2:0] {
		SEC_RED = 3'b001,
		SEC_GREEN = 3'b010,
		SEC_BLUE = 3'b100
	} sector_t;

	typedef struct packed {
		logic gray;
		logic black;
		logic neg;
		sector_t sector;
	} pix_ctrl_t;

endpackage

/* rtl/rgb_to_hsv_converter.sv */
// Top level of the pipelined RGB to HSV pixel converter.
// Usage:
// Pixels enter on the pix channel (red_in, green_in, blue_in with pix_valid and
// pix_ready) and results leave on the hsv channel (hue_deg, sat_level, val_level
// with hsv_valid and hsv_ready). Both channels transfer an item on a clock edge
// where valid and ready are both high.
// An input stage finds the largest channel, the hue sector and the two dividends;
// a chain of max(CHANNEL_BITS, 6) division cells then settles one quotient bit per
// cell for hue and saturation together, and an output stage assembles the hue.
// Throughput is one item per cycle while hsv_ready stays high; the depth of the cell chain sets the latency.
// Every stage has its own valid flag, so a stalled receiver only holds the stages
// that are full and gaps in the stream are closed up behind it.
// Reset empties all stages; no other state is kept between items.
module rgb_to_hsv_converter #(
	parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	output logic pix_ready,
	input logic [CHANNEL_BITS-1:0] red_in,
	input logic [CHANNEL_BITS-1:0] green_in,
	input logic [CHANNEL_BITS-1:0] blue_in,
	output logic hsv_valid,
	input logic hsv_ready,
	output logic [rth_pkg::HUE_BITS-1:0] hue_deg,
	output logic [CHANNEL_BITS-1:0] sat_level,
	output logic [CHANNEL_BITS-1:0] val_level
);
	import rth_pkg::*;

	localparam int QUO_BITS = (CHANNEL_BITS > HUE_FRAC_BITS) ? CHANNEL_BITS : HUE_FRAC_BITS;
	localparam int RW = CHANNEL_BITS + QUO_BITS;

	logic c_valid [0:QUO_BITS];
	logic c_ready [0:QUO_BITS];
	pix_ctrl_t c_ctrl [0:QUO_BITS];
	logic [CHANNEL_BITS-1:0] c_max [0:QUO_BITS];
	logic [CHANNEL_BITS-1:0] c_delta [0:QUO_BITS];
	logic [RW-1:0] c_hue_rem [0:QUO_BITS];
	logic [RW-1:0] c_sat_rem [0:QUO_BITS];
	logic [QUO_BITS-1:0] c_hue_quo [0:QUO_BITS];
	logic [QUO_BITS-1:0] c_sat_quo [0:QUO_BITS];

	rth_front #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.QUO_BITS(QUO_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.up_valid(pix_valid),
		.up_ready(pix_ready),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.dn_valid(c_valid[0]),
		.dn_ready(c_ready[0]),
		.dn_ctrl(c_ctrl[0]),
		.dn_max(c_max[0]),
		.dn_delta(c_delta[0]),
		.dn_hue_rem(c_hue_rem[0]),
		.dn_sat_rem(c_sat_rem[0])
	);

	assign c_hue_quo[0] = '0;
	assign c_sat_quo[0] = '0;

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
		rth_div_cell #(
			.CHANNEL_BITS(CHANNEL_BITS),
			.QUO_BITS(QUO_BITS),
			.BIT_IDX(QUO_BITS - 1 - i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.up_valid(c_valid[i]),
			.up_ready(c_ready[i]),
			.up_ctrl(c_ctrl[i]),
			.up_max(c_max[i]),
			.up_delta(c_delta[i]),
			.up_hue_rem(c_hue_rem[i]),
			.up_sat_rem(c_sat_rem[i]),
			.up_hue_quo(c_hue_quo[i]),
			.up_sat_quo(c_sat_quo[i]),
			.dn_valid(c_valid[i+1]),
			.dn_ready(c_ready[i+1]),
			.dn_ctrl(c_ctrl[i+1]),
			.dn_max(c_max[i+1]),
			.dn_delta(c_delta[i+1]),
			.dn_hue_rem(c_hue_rem[i+1]),
			.dn_sat_rem(c_sat_rem[i+1]),
			.dn_hue_quo(c_hue_quo[i+1]),
			.dn_sat_quo(c_sat_quo[i+1])
		);
	end

	rth_back #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.QUO_BITS(QUO_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.up_valid(c_valid[QUO_BITS]),
		.up_ready(c_ready[QUO_BITS]),
		.up_ctrl(c_ctrl[QUO_BITS]),
		.up_max(c_max[QUO_BITS]),
		.up_hue_rem(c_hue_rem[QUO_BITS]),
		.up_hue_quo(c_hue_quo[QUO_BITS]),
		.up_sat_quo(c_sat_quo[QUO_BITS]),
		.dn_valid(hsv_valid),
		.dn_ready(hsv_ready),
		.hue_deg(hue_deg),
		.sat_level(sat_level),
		.val_level(val_level)
	);

endmodule

/* rtl/rth_front.sv */
// Input stage: largest and smallest channel, hue sector and the two dividends.
module rth_front #(
	parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF,
	parameter int QUO_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic up_valid,
	output logic up_ready,
	input logic [CHANNEL_BITS-1:0] red_in,
	input logic [CHANNEL_BITS-1:0] green_in,
	input logic [CHANNEL_BITS-1:0] blue_in,
	output logic dn_valid,
	input logic dn_ready,
	output rth_pkg::pix_ctrl_t dn_ctrl,
	output logic [CHANNEL_BITS-1:0] dn_max,
	output logic [CHANNEL_BITS-1:0] dn_delta,
	output logic [CHANNEL_BITS+QUO_BITS-1:0] dn_hue_rem,
	output logic [CHANNEL_BITS+QUO_BITS-1:0] dn_sat_rem
);
	import rth_pkg::*;

	localparam int RW = CHANNEL_BITS + QUO_BITS;

	logic [CHANNEL_BITS-1:0] mx;
	logic [CHANNEL_BITS-1:0] mn;
	logic [CHANNEL_BITS-1:0] delta;
	logic [CHANNEL_BITS-1:0] opa;
	logic [CHANNEL_BITS-1:0] opb;
	logic [CHANNEL_BITS-1:0] mag;
	logic [RW-1:0] mag_x;
	logic [RW-1:0] delta_x;
	pix_ctrl_t ctrl;

	logic valid_s1;
	pix_ctrl_t ctrl_s1;
	logic [CHANNEL_BITS-1:0] max_s1;
	logic [CHANNEL_BITS-1:0] delta_s1;
	logic [RW-1:0] hue_rem_s1;
	logic [RW-1:0] sat_rem_s1;

	always_comb begin
		if (red_in >= green_in && red_in >= blue_in) begin
			ctrl.sector = SEC_RED;
			mx = red_in;
			opa = green_in;
			opb = blue_in;
		end else if (green_in >= blue_in) begin
			ctrl.sector = SEC_GREEN;
			mx = green_in;
			opa = blue_in;
			opb = red_in;
		end else begin
			ctrl.sector = SEC_BLUE;
			mx = blue_in;
			opa = red_in;
			opb = green_in;
		end
		mn = (opa < opb) ? opa : opb;
		delta = mx - mn;
		ctrl.neg = opa < opb;
		mag = ctrl.neg ? (opb - opa) : (opa - opb);
		ctrl.gray = delta == '0;
		ctrl.black = mx == '0;
		mag_x = {{(RW-CHANNEL_BITS){1'b0}}, mag};
		delta_x = {{(RW-CHANNEL_BITS){1'b0}}, delta};
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// Sixty times the difference is formed as 64x - 4x; full scale times delta as 2^W d - d.
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			ctrl_s1 <= ctrl;
			max_s1 <= mx;
			delta_s1 <= delta;
			hue_rem_s1 <= (mag_x << 6) - (mag_x << 2);
			sat_rem_s1 <= (delta_x << CHANNEL_BITS) - delta_x;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_ctrl = ctrl_s1;
	assign dn_max = max_s1;
	assign dn_delta = delta_s1;
	assign dn_hue_rem = hue_rem_s1;
	assign dn_sat_rem = sat_rem_s1;

endmodule

/* rtl/rth_div_cell.sv */
// One cell of the divider chain: settles one quotient bit of the hue and saturation divisions.
module rth_div_cell #(
	parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF,
	parameter int QUO_BITS = rth_pkg::CHANNEL_BITS_DEF,
	parameter int BIT_IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic up_valid,
	output logic up_ready,
	input rth_pkg::pix_ctrl_t up_ctrl,
	input logic [CHANNEL_BITS-1:0] up_max,
	input logic [CHANNEL_BITS-1:0] up_delta,
	input logic [CHANNEL_BITS+QUO_BITS-1:0] up_hue_rem,
	input logic [CHANNEL_BITS+QUO_BITS-1:0] up_sat_rem,
	input logic [QUO_BITS-1:0] up_hue_quo,
	input logic [QUO_BITS-1:0] up_sat_quo,
	output logic dn_valid,
	input logic dn_ready,
	output rth_pkg::pix_ctrl_t dn_ctrl,
	output logic [CHANNEL_BITS-1:0] dn_max,
	output logic [CHANNEL_BITS-1:0] dn_delta,
	output logic [CHANNEL_BITS+QUO_BITS-1:0] dn_hue_rem,
	output logic [CHANNEL_BITS+QUO_BITS-1:0] dn_sat_rem,
	output logic [QUO_BITS-1:0] dn_hue_quo,
	output logic [QUO_BITS-1:0] dn_sat_quo
);
	import rth_pkg::*;

	localparam int RW = CHANNEL_BITS + QUO_BITS;
	localparam logic [QUO_BITS-1:0] QBIT = {{(QUO_BITS-1){1'b0}}, 1'b1} << BIT_IDX;

	logic [RW-1:0] hue_div;
	logic [RW-1:0] sat_div;
	logic hue_ge;
	logic sat_ge;

	logic valid_q;
	pix_ctrl_t ctrl_q;
	logic [CHANNEL_BITS-1:0] max_q;
	logic [CHANNEL_BITS-1:0] delta_q;
	logic [RW-1:0] hue_rem_q;
	logic [RW-1:0] sat_rem_q;
	logic [QUO_BITS-1:0] hue_quo_q;
	logic [QUO_BITS-1:0] sat_quo_q;
	logic [RW-1:0] chk_hue_div;
	logic [RW-1:0] chk_sat_div;

	assign hue_div = {{(RW-CHANNEL_BITS){1'b0}}, up_delta} << BIT_IDX;
	assign sat_div = {{(RW-CHANNEL_BITS){1'b0}}, up_max} << BIT_IDX;
	assign hue_ge = up_hue_rem >= hue_div;
	assign sat_ge = up_sat_rem >= sat_div;

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			ctrl_q <= up_ctrl;
			max_q <= up_max;
			delta_q <= up_delta;
			hue_rem_q <= hue_ge ? (up_hue_rem - hue_div) : up_hue_rem;
			sat_rem_q <= sat_ge ? (up_sat_rem - sat_div) : up_sat_rem;
			hue_quo_q <= hue_ge ? (up_hue_quo | QBIT) : up_hue_quo;
			sat_quo_q <= sat_ge ? (up_sat_quo | QBIT) : up_sat_quo;
		end
	end

	assign dn_valid = valid_q;
	assign dn_ctrl = ctrl_q;
	assign dn_max = max_q;
	assign dn_delta = delta_q;
	assign dn_hue_rem = hue_rem_q;
	assign dn_sat_rem = sat_rem_q;
	assign dn_hue_quo = hue_quo_q;
	assign dn_sat_quo = sat_quo_q;

	assign chk_hue_div = {{(RW-CHANNEL_BITS){1'b0}}, delta_q} << BIT_IDX;
	assign chk_sat_div = {{(RW-CHANNEL_BITS){1'b0}}, max_q} << BIT_IDX;

	// After each step the partial remainder must lie below the divisor at this bit weight.
	a_hue_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ctrl_q.gray |-> hue_rem_q < chk_hue_div)
		else $error("hue remainder out of range after division step");

	a_sat_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ctrl_q.black |-> sat_rem_q < chk_sat_div)
		else $error("saturation remainder out of range after division step");

endmodule

/* rtl/rth_back.sv */
// Output stage: turns the sector and the hue quotient into degrees and holds the result.
module rth_back #(
	parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF,
	parameter int QUO_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic up_valid,
	output logic up_ready,
	input rth_pkg::pix_ctrl_t up_ctrl,
	input logic [CHANNEL_BITS-1:0] up_max,
	input logic [CHANNEL_BITS+QUO_BITS-1:0] up_hue_rem,
	input logic [QUO_BITS-1:0] up_hue_quo,
	input logic [QUO_BITS-1:0] up_sat_quo,
	output logic dn_valid,
	input logic dn_ready,
	output logic [rth_pkg::HUE_BITS-1:0] hue_deg,
	output logic [CHANNEL_BITS-1:0] sat_level,
	output logic [CHANNEL_BITS-1:0] val_level
);
	import rth_pkg::*;

	logic [HUE_BITS-1:0] frac;
	logic [HUE_BITS-1:0] step;
	logic [HUE_BITS-1:0] hue;
	logic [CHANNEL_BITS-1:0] sat;

	logic valid_q;
	logic [HUE_BITS-1:0] hue_q;
	logic [CHANNEL_BITS-1:0] sat_q;
	logic [CHANNEL_BITS-1:0] val_q;

	// A negative offset is floored, so a non-zero remainder rounds its magnitude up.
	always_comb begin
		frac = {{(HUE_BITS-HUE_FRAC_BITS){1'b0}}, up_hue_quo[HUE_FRAC_BITS-1:0]};
		step = frac + {{(HUE_BITS-1){1'b0}}, (up_hue_rem != '0)};
		case (up_ctrl.sector)
			SEC_RED: hue = up_ctrl.neg ? (HUE_RED_BASE - step) : frac;
			SEC_GREEN: hue = up_ctrl.neg ? (HUE_GREEN_BASE - step) : (HUE_GREEN_BASE + frac);
			SEC_BLUE: hue = up_ctrl.neg ? (HUE_BLUE_BASE - step) : (HUE_BLUE_BASE + frac);
			default: hue = '0;
		endcase
		if (up_ctrl.gray) begin
			hue = '0;
		end
		sat = up_ctrl.black ? '0 : up_sat_quo[CHANNEL_BITS-1:0];
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			hue_q <= hue;
			sat_q <= sat;
			val_q <= up_max;
		end
	end

	assign dn_valid = valid_q;
	assign hue_deg = hue_q;
	assign sat_level = sat_q;
	assign val_level = val_q;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> hue_q < HUE_RED_BASE)
		else $error("hue outside 0 to 359 degrees");

	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && val_q == '0 |-> sat_q == '0 && hue_q == '0)
		else $error("black pixel gave non-zero hue or saturation");

endmodule
